### design/rcsda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsda_pkg
// Shared types and constants for the radio switch debounce and action block.
// ----------------------------------------------------------------------------
package rcsda_pkg;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 48;
	localparam int TIME_W      = 48;
	localparam int POS_W       = 7;
	localparam int CNT_W       = 4;
	localparam int DEB_W       = 24;
	localparam int MASK_W      = 32;

	localparam int MODE_SLOTS  = 6;
	localparam int TABLE_SLOTS = 6;

	localparam logic [CNT_W-1:0] STABLE_SAMPLES_RST = 4'd3;
	localparam logic [DEB_W-1:0] DEBOUNCE_US_RST    = 24'd100000;

	localparam logic [CFG_IDX_W-1:0] REG_STABLE_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_US    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_TABLE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_MASK      = 2'd3;

	localparam logic [1:0] POS_ON  = 2'd1;
	localparam logic [1:0] POS_OFF = 2'd3;

	typedef enum logic [2:0] {
		ACT_KILL   = 3'd0,
		ACT_ARM    = 3'd1,
		ACT_DISARM = 3'd2,
		ACT_UNKILL = 3'd3,
		ACT_MODE   = 3'd4
	} action_t;

	typedef struct packed {
		logic       last;
		logic [4:0] mode_value;
		action_t    code;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r1;
		result_t    r0;
	} push_t;

endpackage

### design/rcsda_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsda_ofifo
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rcsda_ofifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rcsda_pkg::push_t  push,
	output logic              room2,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output rcsda_pkg::result_t head
);
	import rcsda_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign m_axis_tvalid = (count_q != 3'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign room2         = (count_q <= 3'd2);
	assign head          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

endmodule

### design/rc_switch_debounce_action.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_switch_debounce_action
// Debounces radio switch samples and turns accepted edges into commands.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transfer per link event or switch sample;
// tuser selects the kind (0 link event, 1 sample). Output stream (m_axis):
// zero, one or two action transfers per input, tlast on the last action
// caused by that input. Config port: cfg_we with cfg_index/cfg_data, to be
// written only while the block is idle; the block does not enforce this.
// An input is first held in the input register, then evaluated against
// the debounce state once the queue has room, and its actions are written
// to the result queue, whose head drives m_axis. Throughput: one input per
// cycle, limited only by the four-entry result queue, which must have room
// for two actions before an input is evaluated; a stalled receiver backs
// up through the queue and the input register to s_axis_tready.
// Reset: registers return to their defaults, link down, no baseline,
// queue empty.
// ----------------------------------------------------------------------------
module rc_switch_debounce_action (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// link_lost, sample_time_us[47:0], switch_slot[2:0], arm_position[1:0],
	// kill_position[1:0]
	input  logic [rcsda_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// action_code[2:0], mode_value[4:0]
	output logic [rcsda_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [rcsda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcsda_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcsda_pkg::*;

	// config
	logic [CNT_W-1:0]      stable_q;
	logic [DEB_W-1:0]      deb_q;
	logic [CFG_DATA_W-1:0] table_q;
	logic [MASK_W-1:0]     mask_q;

	// debounce state
	logic              link_q;
	logic [POS_W-1:0]  cand_q;
	logic [POS_W-1:0]  prev_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              base_q;

	// input register
	logic              valid_s1;
	logic              req_type_s1;
	logic              link_lost_s1;
	logic [TIME_W-1:0] time_s1;
	logic [POS_W-1:0]  pos_s1;

	logic              room2;
	logic              fire;
	push_t             push;
	result_t           head;

	logic [CNT_W-1:0]  need;
	logic              bad;
	logic              new_cand;
	logic              t_adv;
	logic [CNT_W-1:0]  cnt_nx;
	logic [TIME_W-1:0] age;
	logic              settled;
	logic              emit;

	logic [1:0] ck, pk, ca, pa;
	logic [2:0] cm, pm;
	logic       kill_chg, kill_eng, arm_chg;
	logic       e_k, e_a, e_u, e_m;
	action_t    arm_code;
	logic [2:0] slot_idx;
	logic [7:0] mode_byte;
	logic [1:0] n_res;

	assign fire          = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// pos: slot in 6..4, arm in 3..2, kill in 1..0
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_type_s1  <= s_axis_tuser[0];
			link_lost_s1 <= s_axis_tdata[0];
			time_s1      <= s_axis_tdata[48:1];
			pos_s1       <= {s_axis_tdata[51:49], s_axis_tdata[53:52], s_axis_tdata[55:54]};
		end
	end

	// debounce decision
	always_comb begin
		need     = (stable_q == '0) ? CNT_W'(1) : stable_q;
		bad      = !link_q || (time_s1 == '0) || ((last_q != '0) && (time_s1 < last_q));
		new_cand = (cnt_q == '0) || (pos_s1 != cand_q);
		t_adv    = time_s1 > last_q;
		cnt_nx   = (t_adv && (cnt_q < need)) ? cnt_q + CNT_W'(1) : cnt_q;
		age      = time_s1 - start_q;
		settled  = (cnt_nx >= need) && (age >= TIME_W'(deb_q));
		emit     = req_type_s1 && !bad && !new_cand && settled && base_q;
	end

	// edge to action
	always_comb begin
		ck = cand_q[1:0];
		pk = prev_q[1:0];
		ca = cand_q[3:2];
		pa = prev_q[3:2];
		cm = cand_q[6:4];
		pm = prev_q[6:4];
		kill_chg = ck != pk;
		kill_eng = kill_chg && (ck == POS_ON);
		arm_chg  = ca != pa;
		slot_idx  = cm - 3'd1;
		mode_byte = 8'(table_q >> {slot_idx, 3'b000});
		e_k = kill_eng;
		e_a = arm_chg && ((ca == POS_ON) || (ca == POS_OFF));
		e_u = kill_chg && !kill_eng && (ck == POS_OFF);
		e_m = !kill_chg && !arm_chg && (cm != pm) && (cm != 3'd0)
			&& (32'(cm) <= MODE_SLOTS) && (32'(cm) <= TABLE_SLOTS)
			&& (mode_byte < 8'd32) && mask_q[mode_byte[4:0]];
		arm_code = (ca == POS_ON) ? ACT_ARM : ACT_DISARM;
		n_res = 2'(e_k) + 2'(e_a) + 2'(e_u) + 2'(e_m);

		push.cnt = (fire && emit) ? n_res : 2'd0;
		push.r0.code = e_k ? ACT_KILL : (e_a ? arm_code : (e_u ? ACT_UNKILL : ACT_MODE));
		push.r0.mode_value = (!e_k && !e_a && !e_u) ? mode_byte[4:0] : 5'd0;
		push.r0.last = (n_res == 2'd1);
		push.r1.code = e_k ? arm_code : ACT_UNKILL;
		push.r1.mode_value = 5'd0;
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= STABLE_SAMPLES_RST;
			deb_q    <= DEBOUNCE_US_RST;
			table_q  <= '0;
			mask_q   <= '0;
			link_q   <= 1'b0;
			cand_q   <= '0;
			prev_q   <= '0;
			start_q  <= '0;
			last_q   <= '0;
			cnt_q    <= '0;
			base_q   <= 1'b0;
		end else begin
			if (fire) begin
				if (!req_type_s1) begin
					link_q <= !link_lost_s1;
					if (link_lost_s1) begin
						cand_q  <= '0;
						prev_q  <= '0;
						start_q <= '0;
						last_q  <= '0;
						cnt_q   <= '0;
						base_q  <= 1'b0;
					end
				end else if (bad) begin
					cand_q  <= '0;
					prev_q  <= '0;
					start_q <= '0;
					last_q  <= '0;
					cnt_q   <= '0;
					base_q  <= 1'b0;
				end else if (new_cand) begin
					cand_q  <= pos_s1;
					start_q <= time_s1;
					last_q  <= time_s1;
					cnt_q   <= CNT_W'(1);
				end else begin
					cnt_q <= cnt_nx;
					if (t_adv) begin
						last_q <= time_s1;
					end
					if (settled) begin
						prev_q <= cand_q;
						base_q <= 1'b1;
					end
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STABLE_SAMPLES: stable_q <= cfg_data[CNT_W-1:0];
					REG_DEBOUNCE_US:    deb_q    <= cfg_data[DEB_W-1:0];
					REG_MODE_TABLE: begin
						table_q <= cfg_data;
						if (cfg_data != table_q) begin
							cand_q  <= '0;
							prev_q  <= '0;
							start_q <= '0;
							last_q  <= '0;
							cnt_q   <= '0;
							base_q  <= 1'b0;
						end
					end
					REG_MODE_MASK:      mask_q   <= cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	rcsda_ofifo u_ofifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.room2         (room2),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.head          (head)
	);

	assign m_axis_tdata = {head.mode_value, head.code};
	assign m_axis_tlast = head.last;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radio switch debounce and action block. Sends
// link events and timestamped switch samples, mostly debounce-complete switch
// sequences with random content plus link drops, bad timestamps and stray
// samples. An in-bench predictor tracks debounce and baseline state and queues
// the actions each transfer should cause; every output transfer is checked
// field by field against the oldest queued action. Register settings change
// between phases that idle the source and stall the sink at different rates.
// ----------------------------------------------------------------------------
module tb_top;
	import rcsda_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor copy of registers and debounce state
	logic [CNT_W-1:0]  cfg_need = STABLE_SAMPLES_RST;
	logic [DEB_W-1:0]  cfg_deb = DEBOUNCE_US_RST;
	logic [47:0]       cfg_table = '0;
	logic [MASK_W-1:0] cfg_mask = '0;
	logic              link_up = 1'b0;
	logic [POS_W-1:0]  cand_pos = '0;
	logic [POS_W-1:0]  prev_pos = '0;
	logic [TIME_W-1:0] cand_t0 = '0;
	logic [TIME_W-1:0] last_t = '0;
	logic [CNT_W-1:0]  match_cnt = '0;
	logic              have_base = 1'b0;

	result_t actions_due[$];
	int mismatches = 0;
	int items_sent = 0;
	int src_idle = 0;
	int sink_stall = 0;

	logic [TIME_W-1:0] cur_time = '0;
	logic [2:0]        drv_slot = '0;
	logic [1:0]        drv_arm = '0;
	logic [1:0]        drv_kill = '0;

	rc_switch_debounce_action u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic void note_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t: %s", $time, msg);
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [47:0] fresh_time();
		return {16'($urandom_range(1, 65000)), 32'($urandom())};
	endfunction

	function automatic logic [47:0] random_table();
		logic [47:0] v;
		int r;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				v[i*8 +: 8] = 8'($urandom_range(0, 31));
			else if (r < 85)
				v[i*8 +: 8] = 8'($urandom_range(32, 127));
			else
				v[i*8 +: 8] = 8'($urandom_range(128, 255));
		end
		return v;
	endfunction

	// ---------------- predictor ----------------
	function automatic void clear_baseline();
		cand_pos = '0;
		prev_pos = '0;
		cand_t0 = '0;
		last_t = '0;
		match_cnt = '0;
		have_base = 1'b0;
	endfunction

	function automatic result_t make_action(action_t c, logic [4:0] mv);
		return '{last: 1'b0, mode_value: mv, code: c};
	endfunction

	function automatic int mode_for_slot(logic [2:0] slot);
		logic [7:0] v;
		if (slot == 3'd0 || int'(slot) > MODE_SLOTS || int'(slot) > TABLE_SLOTS)
			return -1;
		v = cfg_table[(int'(slot) - 1) * 8 +: 8];
		if (v >= 8'd32 || !cfg_mask[v[4:0]])
			return -1;
		return int'(v);
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_STABLE_SAMPLES: cfg_need = d[CNT_W-1:0];
			REG_DEBOUNCE_US:    cfg_deb = d[DEB_W-1:0];
			REG_MODE_TABLE: begin
				if (d != cfg_table)
					clear_baseline();
				cfg_table = d;
			end
			REG_MODE_MASK:      cfg_mask = d[MASK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void predict_item(logic kind, logic lost, logic [TIME_W-1:0] t,
		logic [POS_W-1:0] pos);
		logic [CNT_W-1:0] need;
		logic [1:0] kill_now, kill_was, arm_now, arm_was;
		logic [2:0] slot_now, slot_was;
		logic kill_moved, kill_on, arm_moved;
		result_t acts[2];
		int n, m;
		n = 0;
		need = (cfg_need == '0) ? CNT_W'(1) : cfg_need;
		if (!kind) begin
			link_up = !lost;
			if (lost)
				clear_baseline();
			return;
		end
		if (!link_up || t == '0 || (last_t != '0 && t < last_t)) begin
			clear_baseline();
			return;
		end
		if (match_cnt == '0 || pos != cand_pos) begin
			cand_pos = pos;
			cand_t0 = t;
			last_t = t;
			match_cnt = CNT_W'(1);
			return;
		end
		if (t > last_t) begin
			last_t = t;
			if (match_cnt < need)
				match_cnt = match_cnt + 1'b1;
		end
		if (match_cnt < need || (t - cand_t0) < TIME_W'(cfg_deb))
			return;
		if (!have_base) begin
			prev_pos = cand_pos;
			have_base = 1'b1;
			return;
		end
		kill_now = cand_pos[1:0];
		kill_was = prev_pos[1:0];
		arm_now = cand_pos[3:2];
		arm_was = prev_pos[3:2];
		slot_now = cand_pos[6:4];
		slot_was = prev_pos[6:4];
		kill_moved = kill_now != kill_was;
		kill_on = kill_moved && kill_now == POS_ON;
		arm_moved = arm_now != arm_was;
		if (kill_on) begin
			acts[n] = make_action(ACT_KILL, 5'd0);
			n++;
		end
		if (arm_moved && arm_now == POS_ON) begin
			acts[n] = make_action(ACT_ARM, 5'd0);
			n++;
		end else if (arm_moved && arm_now == POS_OFF) begin
			acts[n] = make_action(ACT_DISARM, 5'd0);
			n++;
		end
		if (kill_moved && !kill_on && kill_now == POS_OFF) begin
			acts[n] = make_action(ACT_UNKILL, 5'd0);
			n++;
		end
		if (!kill_moved && !arm_moved && slot_now != slot_was) begin
			m = mode_for_slot(slot_now);
			if (m >= 0) begin
				acts[n] = make_action(ACT_MODE, 5'(m));
				n++;
			end
		end
		prev_pos = cand_pos;
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				acts[i].last = 1'b1;
			actions_due.push_back(acts[i]);
		end
	endfunction

	// input and register monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_item(s_axis_tuser[0], s_axis_tdata[0], s_axis_tdata[48:1],
					{s_axis_tdata[51:49], s_axis_tdata[53:52], s_axis_tdata[55:54]});
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (actions_due.size() == 0) begin
				note_error($sformatf("unexpected action: code %0d mode %0d last %0b",
					m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tlast));
			end else begin
				due = actions_due.pop_front();
				if (m_axis_tdata[2:0] != due.code || m_axis_tdata[7:3] != due.mode_value
					|| m_axis_tlast != due.last)
					note_error($sformatf({"action mismatch: expected code %0d mode %0d last %0b,",
						" got code %0d mode %0d last %0b"}, due.code, due.mode_value, due.last,
						m_axis_tdata[2:0], m_axis_tdata[7:3], m_axis_tlast));
			end
		end
	end

	// sink backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
	end

	// ---------------- stimulus ----------------
	task automatic send_item(logic kind, logic lost, logic [TIME_W-1:0] t, logic [2:0] slot,
		logic [1:0] arm, logic [1:0] kill);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {kill, arm, slot, t, lost};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (actions_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [3:0] need, logic [23:0] deb, logic [47:0] tbl,
		logic [31:0] mask);
		logic [47:0] fill;
		fill = rand48();
		cfg_we <= 1'b1;
		cfg_index <= REG_STABLE_SAMPLES;
		cfg_data <= {fill[47:4], need};
		@(posedge clk);
		cfg_index <= REG_DEBOUNCE_US;
		cfg_data <= {fill[47:24], deb};
		@(posedge clk);
		cfg_index <= REG_MODE_TABLE;
		cfg_data <= tbl;
		@(posedge clk);
		cfg_index <= REG_MODE_MASK;
		cfg_data <= {fill[23:8], mask};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// two matching samples; enough to settle with one sample needed and no delay
	task automatic settle(logic [2:0] s, logic [1:0] a, logic [1:0] k, logic same_time);
		cur_time += 48'd1;
		send_item(1'b1, 1'($urandom_range(0, 1)), cur_time, s, a, k);
		if (!same_time)
			cur_time += 48'd1;
		send_item(1'b1, 1'($urandom_range(0, 1)), cur_time, s, a, k);
	endtask

	task automatic test_reset_defaults();
		send_item(1'b1, 1'b0, 48'd500, 3'd1, POS_OFF, POS_OFF);
		send_item(1'b0, 1'b0, rand48(), 3'd0, 2'd0, 2'd0);
		cur_time = 48'd1000;
		// third sample lands exactly on the default debounce time
		for (int i = 0; i < 6; i++) begin
			send_item(1'b1, 1'b0, cur_time, 3'd1, POS_OFF, (i < 3) ? POS_OFF : POS_ON);
			cur_time += 48'd50000;
		end
		drain();
	endtask

	task automatic test_directed_cases();
		drain();
		// slots 1..6: 5, negative, 40, 31, 7 (masked off), 0
		set_config(4'd0, 24'd0, 48'h00_07_1F_28_85_05, 32'h8000_0021);
		settle(3'd1, POS_OFF, POS_OFF, 1'b1);
		settle(3'd1, POS_OFF, POS_ON, 1'b0);
		settle(3'd1, POS_ON, POS_ON, 1'b0);
		settle(3'd1, POS_OFF, POS_OFF, 1'b0);
		settle(3'd4, POS_OFF, POS_OFF, 1'b0);
		settle(3'd2, POS_OFF, POS_OFF, 1'b0);
		settle(3'd3, POS_OFF, POS_OFF, 1'b0);
		settle(3'd5, POS_OFF, POS_OFF, 1'b0);
		settle(3'd6, POS_OFF, POS_OFF, 1'b0);
		settle(3'd7, 2'd0, 2'd2, 1'b0);
		send_item(1'b1, 1'b0, cur_time - 48'd5, 3'd7, 2'd0, 2'd2);
		send_item(1'b0, 1'b1, rand48(), 3'd7, 2'd3, 2'd3);
		send_item(1'b1, 1'b1, cur_time + 48'd1, 3'd7, 2'd0, 2'd2);
		send_item(1'b0, 1'b0, rand48(), 3'd0, 2'd0, 2'd0);
		cur_time = 48'hFFFF_FFFF_FFFE;
		settle(3'd1, POS_ON, POS_OFF, 1'b1);
		send_item(1'b1, 1'b0, 48'd0, 3'd1, POS_ON, POS_OFF);
		drain();
	endtask

	task automatic test_random_traffic(int src, int sink, logic [3:0] need, logic [23:0] deb,
		int n);
		int stop_at, hold, eff, k, pick;
		logic [47:0] step;
		drain();
		src_idle = src;
		sink_stall = sink;
		set_config(need, deb, random_table(), 32'($urandom() | $urandom()));
		eff = (need == 4'd0) ? 1 : int'(need);
		step = 48'(int'(deb) / eff) + 48'd1;
		stop_at = items_sent + n;
		cur_time = fresh_time();
		send_item(1'b0, 1'b0, rand48(), 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)));
		while (items_sent < stop_at) begin
			k = $urandom_range(0, 99);
			if (k < 3) begin
				drain();
			end else if (k < 8) begin
				send_item(1'b0, 1'b1, rand48(), 3'($urandom_range(0, 7)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
				cur_time = fresh_time();
				if ($urandom_range(0, 2) == 0)
					send_item(1'b1, 1'($urandom_range(0, 1)), cur_time, drv_slot, drv_arm,
						drv_kill);
				send_item(1'b0, 1'b0, rand48(), 3'($urandom_range(0, 7)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			end else if (k < 14) begin
				case ($urandom_range(0, 3))
					0: send_item(1'b1, 1'($urandom_range(0, 1)), 48'd0, 3'($urandom_range(0, 7)),
						2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
					1: send_item(1'b1, 1'($urandom_range(0, 1)),
						cur_time - 48'($urandom_range(1, 1000)), drv_slot, drv_arm, drv_kill);
					2: begin
						cur_time += 48'($urandom_range(0, 5));
						send_item(1'b1, 1'($urandom_range(0, 1)), cur_time,
							3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
							2'($urandom_range(0, 3)));
					end
					default: begin
						cur_time = fresh_time();
						send_item(1'b1, 1'($urandom_range(0, 1)), cur_time, drv_slot, drv_arm,
							drv_kill);
					end
				endcase
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					drv_slot = 3'($urandom_range(0, 7));
				end else if (pick < 6) begin
					drv_arm = 2'($urandom_range(0, 3));
				end else if (pick < 8) begin
					drv_kill = 2'($urandom_range(0, 3));
				end else begin
					drv_slot = 3'($urandom_range(0, 7));
					drv_arm = 2'($urandom_range(0, 3));
					drv_kill = 2'($urandom_range(0, 3));
				end
				hold = eff + 1 + $urandom_range(0, 2);
				for (int i = 0; i < hold; i++) begin
					if (i > 0 && $urandom_range(0, 11) != 0)
						cur_time += step + 48'($urandom_range(0, 20));
					send_item(1'b1, 1'($urandom_range(0, 1)), cur_time, drv_slot, drv_arm,
						drv_kill);
				end
				cur_time += 48'd1;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_cases();
		test_random_traffic(0, 0, 4'($urandom_range(1, 4)), 24'($urandom_range(0, 3000)), 220);
		test_random_traffic(71, 0, 4'd15, 24'd10000000, 220);
		test_random_traffic(0, 71, 4'd1, 24'd0, 230);
		test_random_traffic(17, 17, 4'($urandom_range(1, 15)),
			24'($urandom_range(0, 10000000)), 230);
		s_axis_tvalid <= 1'b0;
		for (int i = 0; i < 20000 && actions_due.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (actions_due.size() != 0)
			note_error($sformatf("%0d expected actions never arrived", actions_due.size()));
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
